### design/lsog_pkg.sv
// Shared constants, types and helper functions of the laser scan occupancy grid.
package lsog_pkg;

   // Grid geometry
   localparam int GRID_DIM  = 300;
   localparam int GRID_HALF = GRID_DIM / 2;
   localparam int CELLS     = GRID_DIM * GRID_DIM;
   localparam int ADDR_W    = $clog2(CELLS);
   localparam int MAX_BEAMS = 1024;

   // Field widths
   localparam int BEAM_W  = 10;
   localparam int RANGE_W = 16;
   localparam int ROW_W   = 9;
   localparam int CELL_W  = 10;
   localparam int ANGLE_W = 16;
   localparam int COORD_W = 20;
   localparam int PROD_W  = 34;
   localparam int ACC_W   = 34;
   localparam int DIV_W   = 18;
   localparam int RD_W    = 2;

   // Beat layout of req_tdata, lowest bit first
   localparam int REQ_BEAM_LSB  = 0;
   localparam int REQ_RANGE_LSB = REQ_BEAM_LSB + BEAM_W;
   localparam int REQ_ROW_LSB   = REQ_RANGE_LSB + RANGE_W;
   localparam int REQ_COL_LSB   = REQ_ROW_LSB + ROW_W;
   localparam int REQ_DATA_W    = 48;
   localparam int RSP_DATA_W    = 8;

   // Opcodes carried in req_tuser
   localparam logic [1:0] OP_CLEAR  = 2'd0;
   localparam logic [1:0] OP_BEAM   = 2'd1;
   localparam logic [1:0] OP_READ   = 2'd2;
   localparam logic [1:0] OP_UNUSED = 2'd3;  // no action, no result

   // Cell states
   localparam logic [1:0] CELL_UNKNOWN = 2'd0;
   localparam logic [1:0] CELL_FREE    = 2'd1;
   localparam logic [1:0] CELL_OCC     = 2'd2;

   // Register indexes
   localparam logic [1:0] CSR_MAX_RANGE   = 2'd0;
   localparam logic [1:0] CSR_CELL_SIZE   = 2'd1;
   localparam logic [1:0] CSR_ANGLE_START = 2'd2;
   localparam logic [1:0] CSR_ANGLE_STEP  = 2'd3;

   // Datapath operations
   typedef enum logic [3:0] {
      DP_NOP, DP_CLEAR, DP_READ, DP_ANGLE, DP_FOLD, DP_SQ, DP_T1, DP_T2,
      DP_MAG, DP_FIN, DP_EMUL, DP_DSTART, DP_DWAIT, DP_WINIT, DP_WALK, DP_END
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      load;      // capture the accepted request beat
      logic      cos_pass;  // sine unit works on angle + quarter turn
      logic      axis_row;  // endpoint divide for row (else column)
   } dp_cmd_type;

   typedef struct packed {
      logic [1:0] opcode;      // opcode of the pending request beat
      logic       beam_ok;     // pending beam passes range and index checks
      logic       clear_last;  // clearing pass at last cell
      logic       div_done;
      logic       walk_more;   // ray point still short of the range
      logic       rsp_busy;    // result register or read still occupied
   } dp_status_type;

   function automatic logic in_grid(input logic signed [COORD_W-1:0] v);
      return !v[COORD_W-1] && (v < $signed(COORD_W'(GRID_DIM)));
   endfunction

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                   input logic [ROW_W-1:0] col);
      return ADDR_W'(ADDR_W'(row) * ADDR_W'(GRID_DIM)) + ADDR_W'(col);
   endfunction

endpackage

### design/lsog_ctrl.sv
// Controller state machine: sequences clear, read and ray-casting beam items.
module lsog_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  lsog_pkg::dp_status_type sts,
   output lsog_pkg::dp_cmd_type    cmd
);

   typedef enum logic [15:0] {
      ST_IDLE   = 16'b0000_0000_0000_0001,
      ST_CLEAR  = 16'b0000_0000_0000_0010,
      ST_READ   = 16'b0000_0000_0000_0100,
      ST_ANGLE  = 16'b0000_0000_0000_1000,
      ST_FOLD   = 16'b0000_0000_0001_0000,
      ST_SQ     = 16'b0000_0000_0010_0000,
      ST_T1     = 16'b0000_0000_0100_0000,
      ST_T2     = 16'b0000_0000_1000_0000,
      ST_MAG    = 16'b0000_0001_0000_0000,
      ST_FIN    = 16'b0000_0010_0000_0000,
      ST_EMUL   = 16'b0000_0100_0000_0000,
      ST_DSTART = 16'b0000_1000_0000_0000,
      ST_DWAIT  = 16'b0001_0000_0000_0000,
      ST_WINIT  = 16'b0010_0000_0000_0000,
      ST_WALK   = 16'b0100_0000_0000_0000,
      ST_END    = 16'b1000_0000_0000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      cos_ff, cos_in;
   logic      axis_ff, axis_in;

   assign req_tready = (state_ff == ST_IDLE);

   // Next state and command decode
   always_comb begin
      state_in     = state_ff;
      cos_in       = cos_ff;
      axis_in      = axis_ff;
      cmd.op       = lsog_pkg::DP_NOP;
      cmd.load     = 1'b0;
      cmd.cos_pass = cos_ff;
      cmd.axis_row = axis_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               if (sts.opcode == lsog_pkg::OP_CLEAR) begin
                  state_in = ST_CLEAR;
               end else if (sts.opcode == lsog_pkg::OP_READ) begin
                  state_in = ST_READ;
               end else if (sts.opcode == lsog_pkg::OP_BEAM && sts.beam_ok) begin
                  state_in = ST_ANGLE;
               end
            end
         end
         ST_CLEAR: begin
            cmd.op = lsog_pkg::DP_CLEAR;
            if (sts.clear_last) state_in = ST_IDLE;
         end
         ST_READ: begin
            if (!sts.rsp_busy) begin
               cmd.op   = lsog_pkg::DP_READ;
               state_in = ST_IDLE;
            end
         end
         ST_ANGLE: begin
            cmd.op   = lsog_pkg::DP_ANGLE;
            cos_in   = 1'b0;
            axis_in  = 1'b0;
            state_in = ST_FOLD;
         end
         ST_FOLD: begin
            cmd.op   = lsog_pkg::DP_FOLD;
            state_in = ST_SQ;
         end
         ST_SQ: begin
            cmd.op   = lsog_pkg::DP_SQ;
            state_in = ST_T1;
         end
         ST_T1: begin
            cmd.op   = lsog_pkg::DP_T1;
            state_in = ST_T2;
         end
         ST_T2: begin
            cmd.op   = lsog_pkg::DP_T2;
            state_in = ST_MAG;
         end
         ST_MAG: begin
            cmd.op   = lsog_pkg::DP_MAG;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            cmd.op = lsog_pkg::DP_FIN;
            if (!cos_ff) begin
               cos_in   = 1'b1;
               state_in = ST_FOLD;
            end else begin
               state_in = ST_EMUL;
            end
         end
         ST_EMUL: begin
            cmd.op   = lsog_pkg::DP_EMUL;
            state_in = ST_DSTART;
         end
         ST_DSTART: begin
            cmd.op   = lsog_pkg::DP_DSTART;
            state_in = ST_DWAIT;
         end
         ST_DWAIT: begin
            cmd.op = lsog_pkg::DP_DWAIT;
            if (sts.div_done) begin
               if (!axis_ff) begin
                  axis_in  = 1'b1;
                  state_in = ST_EMUL;
               end else begin
                  state_in = ST_WINIT;
               end
            end
         end
         ST_WINIT: begin
            cmd.op   = lsog_pkg::DP_WINIT;
            state_in = ST_WALK;
         end
         ST_WALK: begin
            cmd.op = lsog_pkg::DP_WALK;
            if (!sts.walk_more) state_in = ST_END;
         end
         ST_END: begin
            cmd.op   = lsog_pkg::DP_END;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State registers; reset starts the clearing pass
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         cos_ff   <= 1'b0;
         axis_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cos_ff   <= cos_in;
         axis_ff  <= axis_in;
      end
   end

endmodule

### design/lsog_datapath.sv
// Datapath: registers, sine unit, shared multiplier, serial divider, ray walk and cell memory.
module lsog_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [47:0]            req_tdata,
   input  logic [1:0]             req_tuser,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [1:0]             csr_index,
   input  logic [15:0]            csr_data,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [7:0]             rsp_tdata,
   input  lsog_pkg::dp_cmd_type    cmd,
   output lsog_pkg::dp_status_type sts
);

   localparam int AW = lsog_pkg::ADDR_W;
   localparam int CW = lsog_pkg::COORD_W;

   // Configuration registers
   logic [15:0]                    max_range_ff;
   logic [lsog_pkg::CELL_W-1:0]    cell_size_ff;
   logic [15:0]                    angle_start_ff;
   logic [15:0]                    angle_step_ff;
   logic [lsog_pkg::CELL_W-1:0]    cell_eff;

   // Request fields
   logic [lsog_pkg::BEAM_W-1:0]    beam_ff;
   logic [lsog_pkg::RANGE_W-1:0]   range_ff;
   logic [lsog_pkg::ROW_W-1:0]     row_ff, col_ff;
   logic [lsog_pkg::RANGE_W-1:0]   req_range;
   logic [lsog_pkg::BEAM_W-1:0]    req_beam;

   // Sine unit and multiplier
   logic [15:0]                    ang_ff;
   logic [14:0]                    m_ff, z2_ff;
   logic                           neg_ff;
   logic signed [15:0]             sin_ff, cos_ff;
   logic signed [lsog_pkg::PROD_W-1:0] prod_ff;
   logic [15:0]                    mul_a;
   logic signed [16:0]             mul_b;
   logic [15:0]                    fold_ang;
   logic signed [16:0]             fold_s, fold_f;
   logic [19:0]                    mag20;
   logic [14:0]                    mag;
   logic signed [15:0]             sine_val;

   // Serial divider
   logic [lsog_pkg::DIV_W-1:0]     div_a_ff;
   logic [lsog_pkg::CELL_W-1:0]    div_rem_ff;
   logic [4:0]                     div_cnt_ff;
   logic                           div_neg_ff;
   logic [lsog_pkg::CELL_W:0]      rem_sh;
   logic                           rem_ge;
   logic signed [18:0]             div_n;
   logic [19:0]                    div_mag;
   logic signed [CW-1:0]           div_coord;
   logic signed [CW-1:0]           col_e_ff, row_e_ff;

   // Ray walk
   logic [16:0]                    r_ff;
   logic signed [lsog_pkg::ACC_W-1:0] acc_c_ff, acc_s_ff;
   logic signed [CW-1:0]           walk_col, walk_row;

   // Memory and result
   logic [1:0]                     mem [lsog_pkg::CELLS];
   logic [AW-1:0]                  clr_cnt_ff;
   logic                           we;
   logic [AW-1:0]                  waddr;
   logic [1:0]                     wdata;
   logic [1:0]                     rd_q;
   logic                           rd_pend_ff, rd_oob_ff;
   logic                           rsp_valid_ff;
   logic [1:0]                     rsp_cell_ff;
   logic                           rd_in_grid;

   assign csr_ready = 1'b1;
   assign cell_eff  = (cell_size_ff == '0) ? lsog_pkg::CELL_W'(1) : cell_size_ff;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         max_range_ff   <= 16'd6000;
         cell_size_ff   <= lsog_pkg::CELL_W'(40);
         angle_start_ff <= 16'h8000;
         angle_step_ff  <= 16'd182;
      end else if (csr_valid) begin
         case (csr_index)
            lsog_pkg::CSR_MAX_RANGE:   max_range_ff   <= csr_data;
            lsog_pkg::CSR_CELL_SIZE:   cell_size_ff   <= csr_data[lsog_pkg::CELL_W-1:0];
            lsog_pkg::CSR_ANGLE_START: angle_start_ff <= csr_data;
            lsog_pkg::CSR_ANGLE_STEP:  angle_step_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // Status toward the controller
   assign req_beam  = req_tdata[lsog_pkg::REQ_BEAM_LSB +: lsog_pkg::BEAM_W];
   assign req_range = req_tdata[lsog_pkg::REQ_RANGE_LSB +: lsog_pkg::RANGE_W];

   always_comb begin
      sts.opcode     = req_tuser;
      sts.beam_ok    = (req_range <= max_range_ff) &&
                       (32'(req_beam) < 32'(lsog_pkg::MAX_BEAMS));
      sts.clear_last = (clr_cnt_ff == AW'(lsog_pkg::CELLS - 1));
      sts.div_done   = (div_cnt_ff == '0);
      sts.walk_more  = (r_ff < {1'b0, range_ff});
      sts.rsp_busy   = rsp_valid_ff || rd_pend_ff;
   end

   // Angle fold into [-quarter, +quarter] turn
   always_comb begin
      fold_ang = cmd.cos_pass ? (ang_ff + 16'd16384) : ang_ff;
      fold_s   = 17'($signed(fold_ang));
      if (fold_s > 17'sd16384) begin
         fold_f = 17'sd32768 - fold_s;
      end else if (fold_s < -17'sd16384) begin
         fold_f = -17'sd32768 - fold_s;
      end else begin
         fold_f = fold_s;
      end
   end

   // Multiplier operand selection
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         lsog_pkg::DP_SQ: begin
            mul_a = {1'b0, m_ff};
            mul_b = $signed({2'b0, m_ff});
         end
         lsog_pkg::DP_T1: begin
            mul_a = {1'b0, prod_ff[28:14]};
            mul_b = 17'sd2320;
         end
         lsog_pkg::DP_T2: begin
            mul_a = 16'd21024 - prod_ff[29:14];
            mul_b = $signed({2'b0, z2_ff});
         end
         lsog_pkg::DP_MAG: begin
            mul_a = 16'd51472 - prod_ff[29:14];
            mul_b = $signed({2'b0, m_ff});
         end
         lsog_pkg::DP_EMUL: begin
            mul_a = range_ff;
            mul_b = cmd.axis_row ? 17'(sin_ff) : 17'(cos_ff);
         end
         default: ;
      endcase
   end

   // Sine magnitude with clamp and sign
   assign mag20    = prod_ff[33:14];
   assign mag      = (mag20 > 20'd32767) ? 15'h7FFF : mag20[14:0];
   assign sine_val = neg_ff ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

   // Divider step and operand prep
   assign rem_sh    = {div_rem_ff, div_a_ff[lsog_pkg::DIV_W-1]};
   assign rem_ge    = (rem_sh >= {1'b0, cell_eff});
   assign div_n     = prod_ff[33:15];
   assign div_mag   = div_n[18] ? (20'(-div_n) + 20'(cell_eff) - 20'd1) : 20'(div_n);
   assign div_coord = div_neg_ff ? (CW'(lsog_pkg::GRID_HALF) - CW'(div_a_ff))
                                 : (CW'(lsog_pkg::GRID_HALF) + CW'(div_a_ff));

   // Walk point coordinates: floor(k*c / 32768) + half grid
   assign walk_col = CW'($signed(acc_c_ff[lsog_pkg::ACC_W-1:15])) + CW'(lsog_pkg::GRID_HALF);
   assign walk_row = CW'($signed(acc_s_ff[lsog_pkg::ACC_W-1:15])) + CW'(lsog_pkg::GRID_HALF);

   // Datapath registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         beam_ff  <= req_beam;
         range_ff <= req_range;
         row_ff   <= req_tdata[lsog_pkg::REQ_ROW_LSB +: lsog_pkg::ROW_W];
         col_ff   <= req_tdata[lsog_pkg::REQ_COL_LSB +: lsog_pkg::ROW_W];
      end
      case (cmd.op)
         lsog_pkg::DP_ANGLE: ang_ff <= angle_start_ff + 16'(beam_ff * angle_step_ff);
         lsog_pkg::DP_FOLD: begin
            neg_ff <= fold_f[16];
            m_ff   <= fold_f[16] ? 15'(-fold_f) : fold_f[14:0];
         end
         lsog_pkg::DP_SQ, lsog_pkg::DP_T2, lsog_pkg::DP_MAG, lsog_pkg::DP_EMUL:
            prod_ff <= $signed({1'b0, mul_a}) * mul_b;
         lsog_pkg::DP_T1: begin
            z2_ff   <= prod_ff[28:14];
            prod_ff <= $signed({1'b0, mul_a}) * mul_b;
         end
         lsog_pkg::DP_FIN: begin
            if (cmd.cos_pass) cos_ff <= sine_val;
            else              sin_ff <= sine_val;
         end
         lsog_pkg::DP_DSTART: begin
            div_a_ff   <= div_mag[lsog_pkg::DIV_W-1:0];
            div_rem_ff <= '0;
            div_neg_ff <= div_n[18];
         end
         lsog_pkg::DP_DWAIT: begin
            if (div_cnt_ff != '0) begin
               div_a_ff   <= {div_a_ff[lsog_pkg::DIV_W-2:0], rem_ge};
               div_rem_ff <= rem_ge ? lsog_pkg::CELL_W'(rem_sh - {1'b0, cell_eff})
                                    : rem_sh[lsog_pkg::CELL_W-1:0];
            end else if (cmd.axis_row) begin
               row_e_ff <= div_coord;
            end else begin
               col_e_ff <= div_coord;
            end
         end
         lsog_pkg::DP_WINIT: begin
            r_ff     <= 17'(cell_eff);
            acc_c_ff <= lsog_pkg::ACC_W'(cos_ff);
            acc_s_ff <= lsog_pkg::ACC_W'(sin_ff);
         end
         lsog_pkg::DP_WALK: begin
            if (sts.walk_more) begin
               r_ff     <= r_ff + 17'(cell_eff);
               acc_c_ff <= acc_c_ff + lsog_pkg::ACC_W'(cos_ff);
               acc_s_ff <= acc_s_ff + lsog_pkg::ACC_W'(sin_ff);
            end
         end
         default: ;
      endcase
   end

   // Divider bit counter
   always_ff @(posedge clock) begin
      if (reset) begin
         div_cnt_ff <= '0;
      end else if (cmd.op == lsog_pkg::DP_DSTART) begin
         div_cnt_ff <= 5'(lsog_pkg::DIV_W);
      end else if (div_cnt_ff != '0) begin
         div_cnt_ff <= div_cnt_ff - 5'd1;
      end
   end

   // Clearing pass address
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (cmd.op == lsog_pkg::DP_CLEAR) begin
         clr_cnt_ff <= sts.clear_last ? '0 : clr_cnt_ff + AW'(1);
      end
   end

   // Write port selection
   always_comb begin
      we    = 1'b0;
      waddr = clr_cnt_ff;
      wdata = lsog_pkg::CELL_UNKNOWN;
      case (cmd.op)
         lsog_pkg::DP_CLEAR: we = 1'b1;
         lsog_pkg::DP_WALK: begin
            we    = sts.walk_more && lsog_pkg::in_grid(walk_col) &&
                    lsog_pkg::in_grid(walk_row);
            waddr = lsog_pkg::cell_addr(walk_row[lsog_pkg::ROW_W-1:0],
                                        walk_col[lsog_pkg::ROW_W-1:0]);
            wdata = lsog_pkg::CELL_FREE;
         end
         lsog_pkg::DP_END: begin
            we    = lsog_pkg::in_grid(col_e_ff) && lsog_pkg::in_grid(row_e_ff);
            waddr = lsog_pkg::cell_addr(row_e_ff[lsog_pkg::ROW_W-1:0],
                                        col_e_ff[lsog_pkg::ROW_W-1:0]);
            wdata = lsog_pkg::CELL_OCC;
         end
         default: ;
      endcase
   end

   assign rd_in_grid = (row_ff < lsog_pkg::ROW_W'(lsog_pkg::GRID_DIM)) &&
                       (col_ff < lsog_pkg::ROW_W'(lsog_pkg::GRID_DIM));

   // Cell memory: one write and one registered read port
   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      if (cmd.op == lsog_pkg::DP_READ && rd_in_grid)
         rd_q <= mem[lsog_pkg::cell_addr(row_ff, col_ff)];
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_pend_ff <= (cmd.op == lsog_pkg::DP_READ);
         if (rd_pend_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (cmd.op == lsog_pkg::DP_READ) rd_oob_ff <= !rd_in_grid;
      if (rd_pend_ff) rsp_cell_ff <= rd_oob_ff ? lsog_pkg::CELL_UNKNOWN : rd_q;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_cell_ff};

endmodule

### design/laser_scan_occupancy_grid.sv
// Top level: occupancy grid updated by ray casting of laser beams.
// Read item: read through the registered read port once no result is pending;
// the next item can be taken once the read is issued. Beam item: the next acceptance
// waits for the serial sine/divide sequence and one cell write per ray step.
// Clear item: next acceptance waits for the clearing pass, one cell per cycle via the write port.
// Reset is synchronous: control and configuration registers return to defaults and a full
// clearing pass runs with req_tready low; configuration writes are taken meanwhile.
module laser_scan_occupancy_grid (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // beam_index, range_mm, cell_row, cell_col, zero pad
   input  logic [1:0]  req_tuser,  // opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,  // cell_state, zero pad
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   lsog_pkg::dp_cmd_type    cmd;
   lsog_pkg::dp_status_type sts;

   lsog_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   lsog_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .sts        (sts)
   );

endmodule

### design/lsog_checker.sv
// Port-level checker for the occupancy grid, bound to the top level.
module lsog_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [47:0] req_tdata,
   input logic [1:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata,
   input logic        csr_valid,
   input logic        csr_ready,
   input logic [1:0]  csr_index,
   input logic [15:0] csr_data
);

   // Reset starts the clearing pass
   a_reset_blocks: assert property (@(posedge clock) reset |=> !req_tready)
      else $error("request accepted right after reset");

   // A clear beat starts a pass that holds off the next request
   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser == lsog_pkg::OP_CLEAR) |=> !req_tready)
      else $error("request accepted during clearing pass");

   // Stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("result beat changed while stalled");

   // Result beat carries a legal cell state and zero padding
   a_rsp_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[1:0] != 2'd3 && rsp_tdata[7:2] == 6'd0))
      else $error("illegal result beat");

endmodule

bind laser_scan_occupancy_grid lsog_checker u_lsog_checker (.*);

### test/tb.sv
// Self-checking testbench for the laser scan occupancy grid: ray-cast prediction and cell reads.
module tb;

   localparam int LIMIT = 10000000;

   // Predicts the grid contents and holds the cell states that reads must return
   class grid_scoreboard;
      bit [1:0]    cells[lsog_pkg::GRID_DIM*lsog_pkg::GRID_DIM];
      bit [15:0]   max_range;
      bit [9:0]    cell_size;
      bit [15:0]   ang_start;
      bit [15:0]   ang_step;
      bit [1:0]    want_q[$];
      int          touched[$];
      int          errors;

      function void reset_state();
         foreach (cells[i]) cells[i] = lsog_pkg::CELL_UNKNOWN;
         max_range = 6000;
         cell_size = 40;
         ang_start = 16'h8000;
         ang_step  = 182;
      endfunction

      function void set_reg(bit [1:0] idx, bit [15:0] val);
         case (idx)
            lsog_pkg::CSR_MAX_RANGE:   max_range = val;
            lsog_pkg::CSR_CELL_SIZE:   cell_size = val[9:0];
            lsog_pkg::CSR_ANGLE_START: ang_start = val;
            lsog_pkg::CSR_ANGLE_STEP:  ang_step  = val;
         endcase
      endfunction

      // Polynomial sine, Q1.15
      function longint quarter_sine(bit [15:0] ang);
         longint s, m, z2, t, mag;
         s = ang;
         if (s >= 32768) s -= 65536;
         if (s > 16384) s = 32768 - s;
         else if (s < -16384) s = -32768 - s;
         m = (s < 0) ? -s : s;
         z2 = (m * m) >>> 14;
         t = 21024 - ((2320 * z2) >>> 14);
         t = 51472 - ((t * z2) >>> 14);
         mag = (t * m) >>> 14;
         if (mag > 32767) mag = 32767;
         return (s < 0) ? -mag : mag;
      endfunction

      function longint div_floor(longint n, longint d);
         longint q;
         q = n / d;
         if ((n % d) != 0 && n < 0) q--;
         return q;
      endfunction

      function void mark(longint r, longint c, longint s, longint cz, bit [1:0] v);
         longint col, row;
         col = div_floor(r * c, 32768 * cz) + lsog_pkg::GRID_HALF;
         row = div_floor(r * s, 32768 * cz) + lsog_pkg::GRID_HALF;
         if (col < 0 || col >= lsog_pkg::GRID_DIM || row < 0 || row >= lsog_pkg::GRID_DIM)
            return;
         cells[row*lsog_pkg::GRID_DIM + col] = v;
         touched.push_back(int'(row*lsog_pkg::GRID_DIM + col));
         if (touched.size() > 64) void'(touched.pop_front());
      endfunction

      function void cast_beam(bit [9:0] beam, bit [15:0] range);
         longint cz, c, s, r;
         bit [15:0] ang;
         cz = (cell_size == 0) ? 1 : cell_size;
         if (beam >= lsog_pkg::MAX_BEAMS || range > max_range) return;
         ang = 16'(32'(ang_start) + 32'(beam) * 32'(ang_step));
         s = quarter_sine(ang);
         c = quarter_sine(16'(ang + 16'd16384));
         for (r = cz; r < range; r += cz) mark(r, c, s, cz, lsog_pkg::CELL_FREE);
         mark(range, c, s, cz, lsog_pkg::CELL_OCC);
      endfunction

      function void note_item(bit [1:0] op, bit [9:0] beam, bit [15:0] range,
                              bit [8:0] row, bit [8:0] col);
         case (op)
            lsog_pkg::OP_CLEAR: foreach (cells[i]) cells[i] = lsog_pkg::CELL_UNKNOWN;
            lsog_pkg::OP_BEAM:  cast_beam(beam, range);
            lsog_pkg::OP_READ:
               want_q.push_back((row < lsog_pkg::GRID_DIM && col < lsog_pkg::GRID_DIM) ?
                                cells[row*lsog_pkg::GRID_DIM + col] :
                                lsog_pkg::CELL_UNKNOWN);
            default: ;
         endcase
      endfunction

      function void check_cell(bit [1:0] got);
         bit [1:0] want;
         if (want_q.size() == 0) begin
            $error("cell_state: no read pending, got %0d", got);
            errors++;
            return;
         end
         want = want_q.pop_front();
         if (got !== want) begin
            $error("cell_state: expected %0d, actual %0d", want, got);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 0, reset = 1;
   logic        req_tvalid = 0, req_tready;
   logic [47:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid, rsp_tready = 0;
   logic [7:0]  rsp_tdata;
   logic        csr_valid = 0, csr_ready;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_data = '0;
   bit          quiet = 0;
   int          cycles = 0;
   grid_scoreboard sb;

   laser_scan_occupancy_grid dut (.*);

   initial forever #10 clock = ~clock;

   // Watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Result beats
   always @(posedge clock)
      if (!reset && rsp_tvalid && rsp_tready) sb.check_cell(rsp_tdata[1:0]);

   // Receiver stalls
   initial begin
      @(negedge clock);
      forever begin
         if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 0;
            repeat ($urandom_range(1, 7)) @(negedge clock);
         end
         rsp_tready <= 1;
         @(negedge clock);
      end
   end

   task automatic send_item(bit [1:0] op, bit [9:0] beam, bit [15:0] range,
                            bit [8:0] row, bit [8:0] col);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 7)) @(negedge clock);
      end
      req_tvalid <= 1;
      req_tuser  <= op;
      req_tdata  <= {4'b0, col, row, range, beam};
      do @(posedge clock); while (!req_tready);
      sb.note_item(op, beam, range, row, col);
      @(negedge clock);
   endtask

   task automatic write_regs(bit [15:0] mr, bit [15:0] cz, bit [15:0] st, bit [15:0] sp);
      bit [15:0] vals[4];
      vals = '{mr, cz, st, sp};
      for (int i = 0; i < 4; i++) begin
         csr_valid <= 1;
         csr_index <= 2'(i);
         csr_data  <= vals[i];
         do @(posedge clock); while (!csr_ready);
         sb.set_reg(2'(i), vals[i]);
         @(negedge clock);
      end
      csr_valid <= 0;
   endtask

   // Ends with a read so that the block is idle once its beat has come back
   task automatic settle();
      send_item(lsog_pkg::OP_READ, 0, 0, 9'(lsog_pkg::GRID_HALF), 9'(lsog_pkg::GRID_HALF));
      req_tvalid <= 0;
      while (sb.want_q.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic read_any();
      int a;
      if (sb.touched.size() > 0 && $urandom_range(0, 1)) begin
         a = sb.touched[$urandom_range(0, sb.touched.size() - 1)];
         send_item(lsog_pkg::OP_READ, 10'($urandom), 16'($urandom),
                   9'(a / lsog_pkg::GRID_DIM), 9'(a % lsog_pkg::GRID_DIM));
      end else
         send_item(lsog_pkg::OP_READ, 10'($urandom), 16'($urandom), 9'($urandom),
                   9'($urandom));
   endtask

   task automatic random_phase(int n);
      int cz, cap;
      cz = (sb.cell_size == 0) ? 1 : sb.cell_size;
      cap = (cz * 250 < sb.max_range) ? cz * 250 : sb.max_range;
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 19))
            0: send_item(lsog_pkg::OP_UNUSED, 10'($urandom), 16'($urandom), 9'($urandom),
                         9'($urandom));
            1, 2, 3, 4, 5, 6, 7, 8, 9:
               send_item(lsog_pkg::OP_BEAM, 10'($urandom),
                         (cz >= 40 && $urandom_range(0, 9) == 0) ? 16'($urandom) :
                                                                   16'($urandom_range(0, cap)),
                         9'($urandom), 9'($urandom));
            default: read_any();
         endcase
      end
      settle();
   endtask

   initial begin
      sb = new();
      sb.reset_state();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // Directed: defaults, extremes and special cases
      send_item(lsog_pkg::OP_READ, 0, 0, 0, 0);
      send_item(lsog_pkg::OP_READ, 0, 0, 9'd299, 9'd299);
      send_item(lsog_pkg::OP_BEAM, 0, 16'd1000, 0, 0);
      send_item(lsog_pkg::OP_BEAM, 10'd1023, 16'd6000, 0, 0);
      send_item(lsog_pkg::OP_BEAM, 10'd500, 16'd6001, 0, 0);
      send_item(lsog_pkg::OP_BEAM, 10'd250, 16'd0, 0, 0);
      for (int i = 0; i < 6; i++) read_any();
      send_item(lsog_pkg::OP_READ, 0, 0, 9'd300, 9'd511);
      send_item(lsog_pkg::OP_READ, 0, 0, 9'd511, 9'd10);
      send_item(lsog_pkg::OP_UNUSED, 10'h3ff, 16'hffff, 9'h1ff, 9'h1ff);
      send_item(lsog_pkg::OP_CLEAR, 0, 0, 0, 0);
      send_item(lsog_pkg::OP_READ, 0, 0, 9'(lsog_pkg::GRID_HALF), 9'(lsog_pkg::GRID_HALF));
      settle();

      write_regs(16'hffff, 16'd1000, 16'h8000, 16'h8000);
      send_item(lsog_pkg::OP_BEAM, 10'd1, 16'hffff, 0, 0);
      send_item(lsog_pkg::OP_BEAM, 10'd0, 16'hffff, 0, 0);
      for (int i = 0; i < 4; i++) read_any();
      random_phase(400);

      write_regs(16'hffff, 16'd40, 16'd0, 16'd182);
      random_phase(400);

      // Zero cell size behaves as 1 mm
      send_item(lsog_pkg::OP_CLEAR, 0, 0, 0, 0);
      settle();
      write_regs(16'd5000, 16'd0, 16'h7fff, 16'd1);
      random_phase(400);

      quiet = 1;
      write_regs(16'($urandom), 16'($urandom_range(1, 1000)), 16'($urandom), 16'($urandom));
      random_phase(400);

      repeat (50) @(negedge clock);
      if (sb.errors == 0 && sb.want_q.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end
endmodule

### sim.f
design/lsog_pkg.sv
design/lsog_ctrl.sv
design/lsog_datapath.sv
design/laser_scan_occupancy_grid.sv
design/lsog_checker.sv
test/tb.sv
